### src/kwm_pkg.sv
package kwm_pkg;

    // Fixed field widths of the item and result ports.
    localparam int VALUE_W    = 32;
    localparam int LIST_IDX_W = 3;
    localparam int STATUS_W   = 2;

    // Operation carried by an input item.
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_TAKE   = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

### src/kwm_elem_ram.sv
// Element store: one write port, one read port, registered read data.
module kwm_elem_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and read ports; an entry is only read after it has been written.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/kwm_list_table.sv
// Per-list state table (head value, pointers, fill count). A valid bit per
// entry, cleared by reset, makes a never-written entry read back as zero.
module kwm_list_table #(
    parameter int ENTRIES = 8,
    parameter int WIDTH   = 51,
    parameter int ADDR_W  = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0]   r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [WIDTH-1:0]   r_rd_data;
    logic               r_rd_valid;

    // Storage and read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits and the registered valid flag of the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### src/k_way_sorted_merge.sv
// K-way sorted merge. LISTS queues of signed 32-bit values, each LIST_DEPTH
// deep, share one element memory; their pointers, counts and heads sit in a
// second small memory. An append (action 0) pushes a value onto a queue with
// one read of the list table, then, unless the queue is full, the element and
// table writes. A take (action 1) scans the list table one entry a cycle,
// then, when the popped queue is not left empty, fetches its next head from
// the element memory. Ties go to the lowest list index. A take with every
// queue empty returns status 1; an append to a full queue, or to an index at
// or above LISTS, is dropped with status 2. One item is processed at a time;
// a new one is accepted while the previous result waits in the output
// register. Counts and pointers are clear after reset, with no clearing pass.
module k_way_sorted_merge #(
    parameter int LISTS      = 8,
    parameter int LIST_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [kwm_pkg::LIST_IDX_W-1:0]    i_list_index,
    input  logic signed [kwm_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [kwm_pkg::VALUE_W-1:0] o_out_value,
    output logic [kwm_pkg::LIST_IDX_W-1:0]    o_source_list,
    output kwm_pkg::t_status                  o_status
);

    import kwm_pkg::*;

    localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int PTR_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ELEMS  = LISTS * LIST_DEPTH;
    localparam int ADDR_W = $clog2(ELEMS);

    typedef struct packed {
        logic signed [VALUE_W-1:0] head;
        logic [PTR_W-1:0]          rd_ptr;
        logic [PTR_W-1:0]          wr_ptr;
        logic [CNT_W-1:0]          count;
    } t_list_entry;

    localparam int ENTRY_W = $bits(t_list_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_POP,
        S_REFILL,
        S_RESULT
    } t_state;

    t_state                    r_state;
    logic [LIST_W-1:0]         r_list;
    logic signed [VALUE_W-1:0] r_value;
    logic [LIST_W-1:0]         r_scan_idx;
    logic                      r_issue_done;
    logic                      r_cmp_valid;
    logic [LIST_W-1:0]         r_cmp_idx;
    logic                      r_found;
    t_list_entry               r_best;
    logic [LIST_W-1:0]         r_best_idx;
    logic signed [VALUE_W-1:0] r_res_value;
    logic [LIST_IDX_W-1:0]     r_res_source;
    t_status                   r_res_status;
    logic                      r_o_valid;
    logic signed [VALUE_W-1:0] r_o_value;
    logic [LIST_IDX_W-1:0]     r_o_source;
    t_status                   r_o_status;

    logic                      w_in_xfer;
    logic                      w_index_ok;
    logic [LIST_W-1:0]         w_in_list;
    t_list_entry               w_entry;
    logic                      w_tbl_rd_en;
    logic [LIST_W-1:0]         w_tbl_rd_addr;
    logic                      w_tbl_wr_en;
    t_list_entry               w_tbl_wr_data;
    logic [ENTRY_W-1:0]        w_tbl_rd_bits;
    logic                      w_elem_wr_en;
    logic [ADDR_W-1:0]         w_elem_wr_addr;
    logic                      w_elem_rd_en;
    logic [ADDR_W-1:0]         w_elem_rd_addr;
    logic [VALUE_W-1:0]        w_elem_rd_data;
    logic                      w_app_full;
    logic                      w_better;
    logic [PTR_W-1:0]          w_pop_rd_ptr;
    logic [CNT_W-1:0]          w_pop_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [LIST_W-1:0] l,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(ADDR_W'(l) * ADDR_W'(LIST_DEPTH)) + ADDR_W'(p);
    endfunction

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_index_ok = (32'(i_list_index) < LISTS);
    assign w_in_list  = LIST_W'(i_list_index);
    assign w_entry    = t_list_entry'(w_tbl_rd_bits);

    // Decisions made on the list-table read data.
    assign w_app_full   = (w_entry.count == CNT_W'(LIST_DEPTH));
    assign w_better     = r_cmp_valid && (w_entry.count != '0) &&
                          (!r_found || (w_entry.head < r_best.head));
    assign w_pop_rd_ptr = next_ptr(r_best.rd_ptr);
    assign w_pop_count  = r_best.count - 1'b1;

    // Memory port control. Reads of the list table happen only during the
    // append lookup and the scan, writes only after them, so no entry is
    // read and written in the same cycle.
    always_comb begin
        w_tbl_rd_en    = 1'b0;
        w_tbl_rd_addr  = r_scan_idx;
        w_tbl_wr_en    = 1'b0;
        w_tbl_wr_data  = r_best;
        w_elem_wr_en   = 1'b0;
        w_elem_wr_addr = elem_addr(r_list, w_entry.wr_ptr);
        w_elem_rd_en   = 1'b0;
        w_elem_rd_addr = elem_addr(r_best_idx, w_pop_rd_ptr);
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_action == ACT_APPEND) && w_index_ok) begin
                    w_tbl_rd_en   = 1'b1;
                    w_tbl_rd_addr = w_in_list;
                end
            end
            S_APPEND: begin
                if (!w_app_full) begin
                    w_elem_wr_en         = 1'b1;
                    w_tbl_wr_en          = 1'b1;
                    w_tbl_wr_data        = w_entry;
                    w_tbl_wr_data.head   = (w_entry.count == '0) ? r_value : w_entry.head;
                    w_tbl_wr_data.wr_ptr = next_ptr(w_entry.wr_ptr);
                    w_tbl_wr_data.count  = w_entry.count + 1'b1;
                end
            end
            S_SCAN: begin
                w_tbl_rd_en = !r_issue_done;
            end
            S_POP: begin
                if (r_found) begin
                    w_tbl_wr_data.rd_ptr = w_pop_rd_ptr;
                    w_tbl_wr_data.count  = w_pop_count;
                    if (w_pop_count != '0) begin
                        w_elem_rd_en = 1'b1;
                    end else begin
                        w_tbl_wr_en = 1'b1;
                    end
                end
            end
            S_REFILL: begin
                w_tbl_wr_en   = 1'b1;
                w_tbl_wr_data = r_best;
                w_tbl_wr_data.head = w_elem_rd_data;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, result register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue_done <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            // A drained output register empties unless a new result loads it.
            if (r_o_valid && i_ready && (r_state != S_RESULT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_list       <= w_in_list;
                        r_value      <= i_value;
                        r_res_value  <= '0;
                        r_res_source <= '0;
                        r_scan_idx   <= '0;
                        r_issue_done <= 1'b0;
                        r_cmp_valid  <= 1'b0;
                        r_found      <= 1'b0;
                        if (i_action == ACT_TAKE) begin
                            r_state <= S_SCAN;
                        end else if (w_index_ok) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_res_status <= ST_FULL;
                            r_state      <= S_RESULT;
                        end
                    end
                end
                S_APPEND: begin
                    r_res_status <= w_app_full ? ST_FULL : ST_OK;
                    r_state      <= S_RESULT;
                end
                S_SCAN: begin
                    // Issue one table read a cycle and compare the one before.
                    if (!r_issue_done) begin
                        r_cmp_valid <= 1'b1;
                        r_cmp_idx   <= r_scan_idx;
                        if (r_scan_idx == LIST_W'(LISTS - 1)) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_scan_idx <= r_scan_idx + 1'b1;
                        end
                    end else begin
                        r_cmp_valid <= 1'b0;
                    end
                    if (w_better) begin
                        r_found    <= 1'b1;
                        r_best     <= w_entry;
                        r_best_idx <= r_cmp_idx;
                    end
                    if (r_issue_done && !r_cmp_valid) begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (!r_found) begin
                        r_res_status <= ST_EMPTY;
                        r_state      <= S_RESULT;
                    end else begin
                        r_res_status  <= ST_OK;
                        r_res_value   <= r_best.head;
                        r_res_source  <= LIST_IDX_W'(r_best_idx);
                        r_best.rd_ptr <= w_pop_rd_ptr;
                        r_best.count  <= w_pop_count;
                        r_state       <= (w_pop_count != '0) ? S_REFILL : S_RESULT;
                    end
                end
                S_REFILL: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // Load the output register once it is free or draining.
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_value  <= r_res_value;
                        r_o_source <= r_res_source;
                        r_o_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_value   = r_o_value;
    assign o_source_list = r_o_source;
    assign o_status      = r_o_status;

    kwm_list_table #(
        .ENTRIES (LISTS),
        .WIDTH   (ENTRY_W),
        .ADDR_W  (LIST_W)
    ) u_list_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_tbl_wr_en),
        .i_wr_addr (r_state == S_APPEND ? r_list : r_best_idx),
        .i_wr_data (w_tbl_wr_data),
        .i_rd_en   (w_tbl_rd_en),
        .i_rd_addr (w_tbl_rd_addr),
        .o_rd_data (w_tbl_rd_bits)
    );

    kwm_elem_ram #(
        .DEPTH  (ELEMS),
        .WIDTH  (VALUE_W),
        .ADDR_W (ADDR_W)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_elem_wr_en),
        .i_wr_addr (w_elem_wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (w_elem_rd_en),
        .i_rd_addr (w_elem_rd_addr),
        .o_rd_data (w_elem_rd_data)
    );

endmodule
